FILE: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared constants and types for the Playfair digraph encryptor
// Letter codes, key-square geometry, config register indexes and the
// request structs passed between the builder, pair stage and cipher stage.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int LETTERS     = 26;
    localparam int SIDE        = 5;
    localparam int CELLS       = SIDE * SIDE;
    localparam int LETTER_W    = 5;
    localparam int COORD_W     = 3;
    localparam int POS_W       = 2 * COORD_W;
    localparam int KEY_MAX_DEF = 12;
    localparam int KEY_BITS    = 60;
    localparam int LEN_W       = 4;
    localparam int CFG_DATA_W  = 60;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [LETTER_W-1:0] LETTER_A = 5'd0;
    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;
    localparam logic [LETTER_W-1:0] LETTER_END = 5'd26;

    localparam logic [COORD_W-1:0] COORD_LAST = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 1'b1;

    // Square write request from the builder
    typedef struct packed {
        logic                en;
        logic [LETTER_W-1:0] slot;
        logic [LETTER_W-1:0] letter;
        logic [POS_W-1:0]    pos;
    } sq_wr_t;

    // Plaintext pair handed to the cipher stage
    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                last;
    } pair_t;

    // Next letter of the alphabet, z wraps to a
    function automatic logic [LETTER_W-1:0] next_letter(input logic [LETTER_W-1:0] c);
        next_letter = (c == LETTER_Z) ? LETTER_A : c + 5'd1;
    endfunction

    // Row or column step modulo the square side
    function automatic logic [COORD_W-1:0] next_coord(input logic [COORD_W-1:0] x);
        next_coord = (x == COORD_LAST) ? 3'd0 : x + 3'd1;
    endfunction

    // Letter j shares the cell of i
    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] c);
        fold_j = (c == LETTER_J) ? LETTER_I : c;
    endfunction

endpackage

FILE: rtl/pfe_builder.sv
// ----------------------------------------------------------------------------
// pfe_builder: key registers and key-square build sequencer
// Holds the key registers and, after reset or any register write, walks the
// key letters and then the alphabet, one candidate per cycle, issuing square
// write requests for each new letter.
// ----------------------------------------------------------------------------
module pfe_builder
    import pfe_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  busy,
    output sq_wr_t                wr
);

    localparam int STEPS  = KEY_MAX + LETTERS;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(KEY_MAX);

    logic [KEY_BITS-1:0] key_letters_reg;
    logic [LEN_W-1:0]    key_length_reg;
    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [LETTER_W-1:0] n_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [LETTERS-1:0]  used_reg;

    logic [LEN_W-1:0]    len_eff;
    logic [LETTER_W-1:0] key_sel;
    logic [STEP_W-1:0]   alpha_full;
    logic [LETTER_W-1:0] cand;
    logic                cand_ok;
    logic                take;

    // Saturate key length at the key capacity
    assign len_eff = (key_length_reg > LEN_MAX) ? LEN_MAX : key_length_reg;

    // Select the key letter for this step
    always_comb
    begin
        key_sel = LETTER_A;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (int'(step_reg) == i)
            begin
                key_sel = key_letters_reg[LETTER_W*i +: LETTER_W];
            end
        end
    end

    assign alpha_full = step_reg - STEP_W'(KEY_MAX);

    // Pick the candidate: key letters first, then the alphabet without j
    always_comb
    begin
        if (int'(step_reg) < KEY_MAX)
        begin
            cand    = fold_j(key_sel);
            cand_ok = (int'(step_reg) < int'(len_eff)) && (key_sel < LETTER_END);
        end
        else
        begin
            cand    = alpha_full[LETTER_W-1:0];
            cand_ok = (alpha_full[LETTER_W-1:0] != LETTER_J);
        end
    end

    assign take = busy_reg && cand_ok && !used_reg[cand] && (int'(n_reg) < CELLS);

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_letters_reg <= '0;
            key_length_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_LETTERS: key_letters_reg <= cfg_data[KEY_BITS-1:0];
                CFG_KEY_LENGTH:  key_length_reg  <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Build sequencer: restart on any write, advance one candidate a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            n_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            used_reg <= '0;
        end
        else if (cfg_valid)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            n_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            used_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                used_reg[cand] <= 1'b1;
                n_reg          <= n_reg + 5'd1;
                if (col_reg == COORD_LAST)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 3'd1;
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
            end
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy      = busy_reg;
    assign wr.en     = take;
    assign wr.slot   = n_reg;
    assign wr.letter = cand;
    assign wr.pos    = {row_reg, col_reg};

endmodule

FILE: rtl/pfe_pair.sv
// ----------------------------------------------------------------------------
// pfe_pair: plaintext pairing stage
// Tracks the pending letter, inserts the filler after a doubled letter and
// registers each completed pair for the cipher stage.
// ----------------------------------------------------------------------------
module pfe_pair
    import pfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [LETTER_W-1:0] letter,
    input  logic                last,
    input  logic                take,
    output logic                pair_valid,
    output pair_t               pair,
    output logic                pending
);

    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [LETTER_W-1:0] pend_letter_reg;
    logic [LETTER_W-1:0] pend_letter_next;
    logic                pair_valid_reg;
    pair_t               pair_reg;
    pair_t               pair_next;
    logic                emit;

    // Pair the letter with the pending one
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        emit             = 1'b0;
        pair_next.first  = pend_letter_reg;
        pair_next.second = letter;
        pair_next.last   = last;
        if (letter >= LETTER_END)
        begin
            if (last)
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (!pend_valid_reg)
        begin
            pend_letter_next = letter;
            pend_valid_next  = !last;
        end
        else
        begin
            emit = 1'b1;
            if (letter == pend_letter_reg)
            begin
                pair_next.second = next_letter(pend_letter_reg);
                pend_valid_next  = !last;
            end
            else
            begin
                pend_valid_next = 1'b0;
            end
        end
    end

    // Hold pending letter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
        end
        else if (accept)
        begin
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
        end
    end

    // Load a new pair, drop it once the cipher stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pair_valid_reg <= emit;
        end
        else if (take)
        begin
            pair_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pair_reg <= pair_next;
        end
    end

    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;
    assign pending    = pend_valid_reg;

endmodule

FILE: rtl/pfe_cipher.sv
// ----------------------------------------------------------------------------
// pfe_cipher: key-square lookup pipeline
// Holds the key square and the letter position table, looks up both letter
// positions, applies the row, column or rectangle rule and reads the two
// cipher letters into the output register.
// ----------------------------------------------------------------------------
module pfe_cipher
    import pfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  sq_wr_t              wr,
    input  logic                pair_valid,
    input  pair_t               pair,
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LETTER_W-1:0] first_cipher,
    output logic [LETTER_W-1:0] second_cipher,
    output logic                message_end
);

    logic [LETTER_W-1:0] square_mem [CELLS];
    logic [POS_W-1:0]    pos_mem [LETTERS];

    logic                v2_reg;
    logic                end2_reg;
    logic [POS_W-1:0]    pos_a_reg;
    logic [POS_W-1:0]    pos_b_reg;
    logic                v3_reg;
    logic                end3_reg;
    logic [LETTER_W-1:0] c0_reg;
    logic [LETTER_W-1:0] c1_reg;

    logic                adv2;
    logic                adv3;
    logic [COORD_W-1:0]  ra, ca, rb, cb;
    logic [COORD_W-1:0]  r0, c0, r1, c1;
    logic [LETTER_W-1:0] addr0;
    logic [LETTER_W-1:0] addr1;

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;

    // Fill both tables from builder requests
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            square_mem[wr.slot] <= wr.letter;
            pos_mem[wr.letter]  <= wr.pos;
        end
    end

    // Position lookup stage
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            pos_a_reg <= pos_mem[fold_j(pair.first)];
            pos_b_reg <= pos_mem[fold_j(pair.second)];
            end2_reg  <= pair.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= pair_valid;
        end
    end

    // Apply the same-row, same-column or rectangle rule
    always_comb
    begin
        ra = pos_a_reg[POS_W-1:COORD_W];
        ca = pos_a_reg[COORD_W-1:0];
        rb = pos_b_reg[POS_W-1:COORD_W];
        cb = pos_b_reg[COORD_W-1:0];
        if (ra == rb)
        begin
            r0 = ra;
            c0 = next_coord(ca);
            r1 = rb;
            c1 = next_coord(cb);
        end
        else if (ca == cb)
        begin
            r0 = next_coord(ra);
            c0 = ca;
            r1 = next_coord(rb);
            c1 = cb;
        end
        else
        begin
            r0 = ra;
            c0 = cb;
            r1 = rb;
            c1 = ca;
        end
        // Cell index is row * 5 + col, built as row * 4 + row + col
        addr0 = {r0, 2'b00} + {2'b00, r0} + {2'b00, c0};
        addr1 = {r1, 2'b00} + {2'b00, r1} + {2'b00, c1};
    end

    // Square read stage doubles as the output register
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            c0_reg   <= square_mem[addr0];
            c1_reg   <= square_mem[addr1];
            end3_reg <= end2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v3_reg <= v2_reg;
        end
    end

    assign take          = adv2;
    assign out_valid     = v3_reg;
    assign first_cipher  = c0_reg;
    assign second_cipher = c1_reg;
    assign message_end   = end3_reg;

endmodule

FILE: rtl/playfair_digraph_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt: Playfair digraph encryptor, top level
//
// Usage:
//   cfg channel writes key_letters (index 0) and key_length (index 1); every
//   write restarts the key-square build, which walks the key letters and
//   then the alphabet, one candidate letter per cycle through the builder.
//   The same build runs right after reset, so the square holds the plain
//   alphabet before the first letter is taken. s_tready stays low while the
//   square is being built; cfg_ready is always high.
//   s channel takes one plaintext letter per cycle while s_tready is high (s_tlast
//   marks the last letter). Every second letter, or a doubled letter, completes a pair.
//   m channel returns one cipher pair per request; m_tlast flags the pair
//   made by the last letter. The edge that accepts the letter completing a
//   pair loads the pair register, then the position lookup registers and
//   then the square read register are loaded, and the pair is offered on
//   m_tvalid. Throughput is one letter per cycle while m_tready is high and
//   no key-square build is running.
//   When m_tready is low the result holds and the earlier stages keep
//   filling until every stage is occupied, then s_tready drops.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt
    import pfe_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // cfg channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // plaintext channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [4:0] letter, [7:5] zero
    input  logic                   s_tlast,
    // cipher channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [4:0] first_cipher, [9:5] second_cipher
    output logic                   m_tlast
);

    logic                busy;
    sq_wr_t              wr;
    logic                accept;
    logic                take;
    logic                pair_valid;
    pair_t               pair;
    logic                pending;
    logic [LETTER_W-1:0] first_cipher;
    logic [LETTER_W-1:0] second_cipher;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy && (!pair_valid || take);
    assign accept    = s_tvalid && s_tready;

    pfe_builder #(
        .KEY_MAX (KEY_MAX)
    ) u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .wr        (wr)
    );

    pfe_pair u_pair (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .letter     (s_tdata[LETTER_W-1:0]),
        .last       (s_tlast),
        .take       (take),
        .pair_valid (pair_valid),
        .pair       (pair),
        .pending    (pending)
    );

    pfe_cipher u_cipher (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .pair_valid    (pair_valid),
        .pair          (pair),
        .take          (take),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .first_cipher  (first_cipher),
        .second_cipher (second_cipher),
        .message_end   (m_tlast)
    );

    assign m_tdata = {{(OUT_TDATA_W - 2*LETTER_W){1'b0}}, second_cipher, first_cipher};

    // No letter is taken while the square is being rebuilt
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !s_tready)
        else $error("letter accepted during key-square build");

    // A register write always starts a build
    assert property (@(posedge clk) disable iff (!rst_n) (cfg_valid && cfg_ready) |=> busy)
        else $error("config write did not start a build");

    // The last letter of a message leaves nothing pending
    assert property (@(posedge clk) disable iff (!rst_n) (accept && s_tlast) |=> !pending)
        else $error("letter left pending after end of message");

    // A non-letter code never completes a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tdata[LETTER_W-1:0] >= LETTER_END)) |=> !pair_valid)
        else $error("pair produced from a non-letter code");

endmodule

FILE: bench/playfair_digraph_encrypt_tb.sv
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_tb: self-checking bench for the Playfair encryptor
// Drives plaintext letters and key writes through the stream and config
// channels. A tracker keeps its own key square, position table and pending
// letter, predicts each cipher pair and checks every pair the block returns.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_tb;
    import pfe_pkg::*;

    localparam int ROW_STRIDE    = 8;
    localparam int MAX_GAP       = 13;
    localparam int LONG_STALL    = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASES        = 14;
    localparam int PHASE_LETTERS = 125;

    typedef struct {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                message_end;
    } cipher_pair_t;

    // Key square tracker and store of pending cipher pairs
    class playfair_tracker;
        logic [KEY_BITS-1:0] key_letters;
        logic [LEN_W-1:0]    key_length;
        logic [LETTER_W-1:0] square [CELLS];
        logic [POS_W-1:0]    where [LETTERS];
        bit                  held;
        logic [LETTER_W-1:0] held_letter;
        cipher_pair_t        expected_pairs [$];
        int                  errors;

        function new();
            key_letters = '0;
            key_length  = '0;
            held        = 0;
            held_letter = '0;
            errors      = 0;
            rebuild_square();
        endfunction

        // Lay out key letters, then the remaining alphabet without j
        function void rebuild_square();
            bit taken [LETTERS];
            int n;
            int count;
            int c;
            n     = 0;
            count = (key_length > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_length);
            foreach (taken[i])
                taken[i] = 0;
            for (int k = 0; k < count; k++)
            begin
                c = int'(key_letters[5*k +: 5]);
                if (c >= LETTERS)
                    continue;
                if (c == LETTER_J)
                    c = LETTER_I;
                if (!taken[c] && n < CELLS)
                begin
                    taken[c]  = 1;
                    square[n] = LETTER_W'(c);
                    n++;
                end
            end
            for (c = 0; c < LETTERS; c++)
            begin
                if (c != LETTER_J && !taken[c] && n < CELLS)
                begin
                    taken[c]  = 1;
                    square[n] = LETTER_W'(c);
                    n++;
                end
            end
            for (int k = 0; k < CELLS; k++)
                where[square[k]] = POS_W'((k / SIDE) * ROW_STRIDE + k % SIDE);
            where[LETTER_J] = where[LETTER_I];
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_KEY_LETTERS)
                key_letters = val;
            else
                key_length = val[LEN_W-1:0];
            rebuild_square();
        endfunction

        // Apply row, column or rectangle rule to one pair
        function cipher_pair_t encipher(input logic [LETTER_W-1:0] a,
                                        input logic [LETTER_W-1:0] b);
            cipher_pair_t p;
            int ra;
            int ca;
            int rb;
            int cb;
            ra = (where[a] / ROW_STRIDE) % SIDE;
            ca = (where[a] % ROW_STRIDE) % SIDE;
            rb = (where[b] / ROW_STRIDE) % SIDE;
            cb = (where[b] % ROW_STRIDE) % SIDE;
            if (ra == rb)
            begin
                p.first  = square[ra * SIDE + (ca + 1) % SIDE];
                p.second = square[rb * SIDE + (cb + 1) % SIDE];
            end
            else if (ca == cb)
            begin
                p.first  = square[((ra + 1) % SIDE) * SIDE + ca];
                p.second = square[((rb + 1) % SIDE) * SIDE + cb];
            end
            else
            begin
                p.first  = square[ra * SIDE + cb];
                p.second = square[rb * SIDE + ca];
            end
            p.message_end = 0;
            return p;
        endfunction

        // Pair up an accepted letter and queue the pair it completes
        function void take_letter(input logic [LETTER_W-1:0] l, input logic last);
            cipher_pair_t        p;
            logic [LETTER_W-1:0] filler;
            if (l >= LETTERS)
            begin
                if (last)
                    held = 0;
                return;
            end
            if (!held)
            begin
                held_letter = l;
                held        = !last;
                return;
            end
            if (l == held_letter)
            begin
                filler = (held_letter == LETTER_Z) ? LETTER_A : held_letter + 5'd1;
                p      = encipher(held_letter, filler);
                held   = !last;
            end
            else
            begin
                p    = encipher(held_letter, l);
                held = 0;
            end
            p.message_end = last;
            expected_pairs = {expected_pairs, p};
        endfunction

        function void check_pair(input logic [LETTER_W-1:0] first,
                                 input logic [LETTER_W-1:0] second,
                                 input logic msg_end);
            cipher_pair_t e;
            if (expected_pairs.size() == 0)
            begin
                $display("%0t unexpected pair: expected none, actual %0d %0d end %0b",
                         $time, first, second, msg_end);
                errors++;
                return;
            end
            e = expected_pairs.pop_front();
            if (first !== e.first)
            begin
                $display("%0t first_cipher mismatch: expected %0d, actual %0d",
                         $time, e.first, first);
                errors++;
            end
            if (second !== e.second)
            begin
                $display("%0t second_cipher mismatch: expected %0d, actual %0d",
                         $time, e.second, second);
                errors++;
            end
            if (msg_end !== e.message_end)
            begin
                $display("%0t message_end mismatch: expected %0b, actual %0b",
                         $time, e.message_end, msg_end);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_pairs.size() != 0)
            begin
                $display("%0t missing pairs: expected %0d more, actual 0",
                         $time, expected_pairs.size());
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [4:0] letter, [7:5] zero
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [4:0] first_cipher, [9:5] second_cipher
    logic                   m_tlast;

    playfair_tracker tracker = new();
    bit              tx_eager;
    bit              rx_eager;
    bit              stall_req;
    int              letters_sent;

    playfair_digraph_encrypt DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one letter after a random gap and hold it until accepted
    task automatic send_letter(input logic [LETTER_W-1:0] l, input logic last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, l};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_letter(l, last);
        letters_sent++;
        @(negedge clk);
    endtask

    // Write one key register, raising the request at the next falling clock edge
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until the block has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.expected_pairs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_key(input bit raw);
        logic [CFG_DATA_W-1:0] k;
        k = CFG_DATA_W'({$urandom, $urandom});
        if (!raw)
        begin
            for (int i = 0; i < KEY_MAX_DEF; i++)
                k[5*i +: 5] = ($urandom_range(0, 7) == 0) ? LETTER_W'($urandom_range(26, 31))
                                                           : LETTER_W'($urandom_range(0, 25));
        end
        return k;
    endfunction

    // Pick a key setting for the next phase, extremes included
    task automatic pick_key();
        logic [CFG_DATA_W-1:0] key;
        logic [CFG_DATA_W-1:0] len;
        int                    which;
        len = CFG_DATA_W'($urandom_range(0, 15));
        case ($urandom_range(0, 6))
            0:
            begin
                key = '0;
                len = '0;
            end
            1:
            begin
                key = '1;
                len = CFG_DATA_W'(KEY_MAX_DEF);
            end
            2:
            begin
                key = random_key(1);
                len = CFG_DATA_W'(15);
            end
            3:
            begin
                key = random_key(0);
                len = CFG_DATA_W'(KEY_MAX_DEF);
            end
            default:
                key = random_key(0);
        endcase
        which = $urandom_range(0, 5);
        if (which == 0)
            write_cfg(CFG_KEY_LETTERS, key);
        else if (which == 1)
            write_cfg(CFG_KEY_LENGTH, len);
        else if (which == 2)
        begin
            write_cfg(CFG_KEY_LENGTH, len);
            write_cfg(CFG_KEY_LETTERS, key);
        end
        else
        begin
            write_cfg(CFG_KEY_LETTERS, key);
            write_cfg(CFG_KEY_LENGTH, len);
        end
    endtask

    // Send a message of letters with doubles, j and invalid codes mixed in, or a stray item
    task automatic send_message();
        int                  len;
        int                  r;
        logic [LETTER_W-1:0] prev;
        logic [LETTER_W-1:0] l;
        prev = LETTER_W'($urandom_range(0, 25));
        if ($urandom_range(0, 9) == 0)
        begin
            send_letter(LETTER_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            return;
        end
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 11);
            if (r < 3)
                l = prev;
            else if (r == 3)
                l = $urandom_range(0, 1) ? LETTER_J : LETTER_I;
            else if (r == 4)
                l = LETTER_W'($urandom_range(26, 31));
            else
                l = LETTER_W'($urandom_range(0, 25));
            send_letter(l, i == len - 1);
            prev = l;
        end
    endtask

    // Return path: random ready gaps, one long stall on request
    initial
    begin : pair_sink
        int wait_cycles;
        bit stall_done;
        m_tready   = 1'b0;
        stall_done = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (stall_req && !stall_done)
            begin
                stall_done = 1;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            wait_cycles = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
            if (wait_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            tracker.check_pair(m_tdata[4:0], m_tdata[9:5], m_tlast);
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        rst_n        = 1'b0;
        tx_eager     = 0;
        rx_eager     = 0;
        stall_req    = 0;
        letters_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Plain alphabet square: row, column, rectangle and the i/j cell
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd5, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(LETTER_Z, 1'b0);
        send_letter(LETTER_I, 1'b0);
        send_letter(LETTER_J, 1'b0);
        // Doubled z wraps its filler to a, then z pairs with y
        send_letter(LETTER_Z, 1'b0);
        send_letter(LETTER_Z, 1'b0);
        send_letter(5'd24, 1'b0);
        // Doubled letter on the final input
        send_letter(5'd23, 1'b0);
        send_letter(5'd23, 1'b1);
        // Lone trailing letter is dropped
        send_letter(5'd16, 1'b1);
        // Invalid code with last drops the pending letter
        send_letter(5'd2, 1'b0);
        send_letter(5'd31, 1'b1);
        send_letter(LETTER_END, 1'b0);
        send_letter(5'd3, 1'b0);
        send_letter(5'd29, 1'b0);
        send_letter(5'd4, 1'b1);
        settle();

        // Key with repeats, j, an invalid code and an oversized length
        write_cfg(CFG_KEY_LETTERS, {5'd23, 5'd4, 5'd31, 5'd9, 5'd17, 5'd8,
                                    5'd0, 5'd5, 5'd24, 5'd0, 5'd11, 5'd15});
        write_cfg(CFG_KEY_LENGTH, 60'd15);
        send_letter(LETTER_J, 1'b0);
        send_letter(5'd0, 1'b1);
        send_letter(5'd11, 1'b0);
        send_letter(5'd24, 1'b1);

        // Random phases, each under a fresh key setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            pick_key();
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                tx_eager  = 1;
                stall_req = 1;
            end
            letters_sent = 0;
            while (letters_sent < PHASE_LETTERS)
                send_message();
        end

        // Drain and report
        s_tvalid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && tracker.expected_pairs.size() != 0; c++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        tracker.check_drained();
        if (tracker.errors == 0)
            $display("PASS playfair_digraph_encrypt");
        else
            $display("FAIL playfair_digraph_encrypt");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(8 * 600000);
        $display("%0t timeout", $time);
        $display("FAIL playfair_digraph_encrypt");
        $finish;
    end

endmodule

FILE: files.f
rtl/pfe_pkg.sv
rtl/pfe_builder.sv
rtl/pfe_pair.sv
rtl/pfe_cipher.sv
rtl/playfair_digraph_encrypt.sv
bench/playfair_digraph_encrypt_tb.sv
